[rtl/dtbg_pkg.sv]
`timescale 1ns / 1ps

package dtbg_pkg;

	localparam int DEF_PACKET_BITS = 64;
	localparam int CNT_W           = 7;
	localparam int REP_W           = 8;
	localparam int IDX_IN_W        = 3;
	localparam int BYTE_W          = 8;
	localparam int IDLE_W          = 64;
	localparam int IDLE_BYTES      = IDLE_W / 8;
	localparam int QDEPTH          = 2;
	localparam int QPTR_W          = $clog2(QDEPTH);
	localparam int CFG_IDX_W       = 2;
	localparam logic [CNT_W-1:0] IDLE_BITS_RST = CNT_W'(64);

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_COMMIT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_WRITE,
		CMD_COMMIT,
		CMD_NOP
	} cmd_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IDLE_DATA    = 2'd0,
		CFG_IDLE_BITS    = 2'd1,
		CFG_IDLE_REPEATS = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [IDX_IN_W-1:0]  byte_index;
		logic [BYTE_W-1:0]    byte_value;
		logic [CNT_W-1:0]     bit_count;
		logic [REP_W-1:0]     repeat_count;
	} cmd_t;

	typedef struct packed {
		logic [QPTR_W:0] count;
		logic            push;
		logic            pop;
	} q_stat_t;

	// zero means one bit, anything past the storage saturates
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n,
			input int unsigned limit);
		logic [CNT_W-1:0] r;
		r = n;
		if (n == '0)
			r = CNT_W'(1);
		else if (32'(n) > limit)
			r = CNT_W'(limit);
		return r;
	endfunction

endpackage

[rtl/dtbg_if.sv]
`timescale 1ns / 1ps

interface dtbg_in_if
	import dtbg_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [1:0]          operation;
	logic [IDX_IN_W-1:0] byte_index;
	logic [BYTE_W-1:0]   byte_value;
	logic [CNT_W-1:0]    bit_count;
	logic [REP_W-1:0]    repeat_count;

	modport source (output valid, operation, byte_index, byte_value, bit_count,
		repeat_count, input ready);
	modport sink (input valid, operation, byte_index, byte_value, bit_count,
		repeat_count, output ready);
endinterface

interface dtbg_out_if;
	logic valid;
	logic ready;
	logic track_level;
	logic bit_in_flight;
	logic pending_full;
	logic accepted;

	modport source (output valid, track_level, bit_in_flight, pending_full, accepted,
		input ready);
	modport sink (input valid, track_level, bit_in_flight, pending_full, accepted,
		output ready);
endinterface

[rtl/dcc_track_bit_generator_top.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Word
// in_ch     in   valid/ready        operation, byte_index, byte_value, bit_count, repeat_count
// out_ch    out  valid/ready        track_level, bit_in_flight, pending_full, accepted
// cfg       in   cfg_wen (no wait)  cfg_index, cfg_data
//
// One word per cycle in and one result per cycle out, sustained while out_ch is ready.
// A word passes through the two-entry command queue and then the output register.
// The queue lets the input side keep taking words while a result waits on out_ch.
// arst_n clears all state but the queue storage at once; there is no clearing pass.
module dcc_track_bit_generator_top
	import dtbg_pkg::*;
#(
	parameter int PACKET_BITS = DEF_PACKET_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dtbg_in_if.sink              in_ch,
	dtbg_out_if.source           out_ch,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IDLE_W-1:0]    cfg_data
);

	cmd_t    cmd;
	logic    cmd_valid;
	logic    cmd_ready;
	q_stat_t q_stat;

	dtbg_front #(
		.PACKET_BITS (PACKET_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.operation    (in_ch.operation),
		.byte_index   (in_ch.byte_index),
		.byte_value   (in_ch.byte_value),
		.bit_count    (in_ch.bit_count),
		.repeat_count (in_ch.repeat_count),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.q_stat       (q_stat)
	);

	dtbg_back #(
		.PACKET_BITS (PACKET_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.track_level   (out_ch.track_level),
		.bit_in_flight (out_ch.bit_in_flight),
		.pending_full  (out_ch.pending_full),
		.accepted      (out_ch.accepted)
	);

	// a refusal only ever happens with a packet pending
	a_refuse_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.accepted |-> out_ch.pending_full)
		else $error("refused word without a pending packet");

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= (QPTR_W + 1)'(QDEPTH))
		else $error("command queue overflow");

	a_q_push: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.push && !q_stat.pop |=> q_stat.count == $past(q_stat.count) + 1'b1)
		else $error("queue count missed a push");

	a_q_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.pop && !q_stat.push |=> q_stat.count == $past(q_stat.count) - 1'b1)
		else $error("queue count missed a pop");

endmodule

[rtl/dtbg_front.sv]
`timescale 1ns / 1ps

module dtbg_front
	import dtbg_pkg::*;
#(
	parameter int PACKET_BITS = DEF_PACKET_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          operation,
	input  logic [IDX_IN_W-1:0] byte_index,
	input  logic [BYTE_W-1:0]   byte_value,
	input  logic [CNT_W-1:0]    bit_count,
	input  logic [REP_W-1:0]    repeat_count,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output cmd_t                cmd,
	output q_stat_t             q_stat
);

	localparam logic [QPTR_W:0] Q_FULL = (QPTR_W + 1)'(QDEPTH);

	cmd_t               dec;
	cmd_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QPTR_W:0]    cnt_q;
	logic               push;
	logic               pop;

	// classify the word and saturate the bit count up front
	always_comb begin
		dec.byte_index   = byte_index;
		dec.byte_value   = byte_value;
		dec.bit_count    = clamp_count(bit_count, PACKET_BITS);
		dec.repeat_count = repeat_count;
		unique case (operation)
			OP_TICK:   dec.kind = CMD_TICK;
			OP_WRITE:  dec.kind = CMD_WRITE;
			OP_COMMIT: dec.kind = CMD_COMMIT;
			default:   dec.kind = CMD_NOP;
		endcase
	end

	assign in_ready  = (cnt_q != Q_FULL);
	assign cmd_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = mem_q[rd_q];

	assign q_stat.count = cnt_q;
	assign q_stat.push  = push;
	assign q_stat.pop   = pop;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[rtl/dtbg_back.sv]
`timescale 1ns / 1ps

module dtbg_back
	import dtbg_pkg::*;
#(
	parameter int PACKET_BITS = DEF_PACKET_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IDLE_W-1:0]    cfg_data,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  cmd_t                 cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 track_level,
	output logic                 bit_in_flight,
	output logic                 pending_full,
	output logic                 accepted
);

	localparam int PACKET_BYTES = PACKET_BITS / 8;
	localparam int WR_BYTES     = (PACKET_BYTES < IDLE_BYTES) ? PACKET_BYTES : IDLE_BYTES;
	localparam int SEL_W        = $clog2(PACKET_BITS);
	localparam logic [SEL_W-1:0] SEL_TOP = SEL_W'(PACKET_BITS - 1);

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_MID,
		PH_FALL,
		PH_TAIL
	} phase_t;

	phase_t                   phase_q, phase_d;
	logic                     level_q, level_d;
	logic                     sbit_q, sbit_d;
	logic [CNT_W-1:0]         pos_q, pos_d;
	logic [PACKET_BITS-1:0]   txd_q, txd_d;
	logic [CNT_W-1:0]         txb_q, txb_d;
	logic [REP_W-1:0]         txr_q, txr_d;
	logic [PACKET_BITS-1:0]   pd_q, pd_d;
	logic [CNT_W-1:0]         pb_q, pb_d;
	logic [REP_W-1:0]         pr_q, pr_d;
	logic                     pv_q, pv_d;
	logic                     acc_d;
	logic [IDLE_W-1:0]        idle_data_q;
	logic [CNT_W-1:0]         idle_bits_q;
	logic [REP_W-1:0]         idle_reps_q;
	logic [PACKET_BITS-1:0]   idle_img;
	logic [SEL_W-1:0]         sel;
	logic [CNT_W-1:0]         pos_nx;
	logic                     take;

	assign cmd_ready = !out_valid || out_ready;
	assign take      = cmd_valid && cmd_ready;
	assign sel       = SEL_TOP - SEL_W'(pos_q);
	assign pos_nx    = pos_q + 1'b1;

	// idle bytes land at the front of storage, the rest reads as zero
	always_comb begin
		idle_img = '0;
		for (int i = 0; i < WR_BYTES; i++)
			idle_img[PACKET_BITS-1-8*i -: 8] = idle_data_q[IDLE_W-1-8*i -: 8];
	end

	always_comb begin
		phase_d = phase_q;
		level_d = level_q;
		sbit_d  = sbit_q;
		pos_d   = pos_q;
		txd_d   = txd_q;
		txb_d   = txb_q;
		txr_d   = txr_q;
		pd_d    = pd_q;
		pb_d    = pb_q;
		pr_d    = pr_q;
		pv_d    = pv_q;
		acc_d   = 1'b1;
		if (take) begin
			unique case (cmd.kind)
				CMD_TICK: begin
					unique case (phase_q)
						PH_LEAD: begin
							level_d = 1'b1;
							phase_d = PH_MID;
							sbit_d  = txd_q[sel];
							pos_d   = pos_nx;
							// end of packet: repeat, take the pending one, or go idle
							if (pos_nx >= txb_q) begin
								pos_d = '0;
								if (txr_q != '0) begin
									txr_d = txr_q - 1'b1;
								end else if (pv_q) begin
									txd_d = pd_q;
									txb_d = pb_q;
									txr_d = pr_q;
									pv_d  = 1'b0;
								end else begin
									txd_d = idle_img;
									txb_d = clamp_count(idle_bits_q, PACKET_BITS);
									txr_d = idle_reps_q;
								end
							end
						end
						PH_MID: begin
							if (sbit_q) begin
								level_d = 1'b0;
								phase_d = PH_LEAD;
							end else begin
								phase_d = PH_FALL;
							end
						end
						PH_FALL: begin
							level_d = 1'b0;
							phase_d = PH_TAIL;
						end
						PH_TAIL: phase_d = PH_LEAD;
						default: phase_d = PH_LEAD;
					endcase
				end
				CMD_WRITE: begin
					if (pv_q) begin
						acc_d = 1'b0;
					end else begin
						for (int i = 0; i < WR_BYTES; i++)
							if (cmd.byte_index == IDX_IN_W'(i))
								pd_d[PACKET_BITS-1-8*i -: 8] = cmd.byte_value;
					end
				end
				CMD_COMMIT: begin
					if (pv_q) begin
						acc_d = 1'b0;
					end else begin
						pb_d = cmd.bit_count;
						pr_d = cmd.repeat_count;
						pv_d = 1'b1;
					end
				end
				CMD_NOP: acc_d = 1'b1;
				default: acc_d = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LEAD;
			level_q       <= 1'b0;
			sbit_q        <= 1'b0;
			pos_q         <= '0;
			txd_q         <= '0;
			txb_q         <= clamp_count(IDLE_BITS_RST, PACKET_BITS);
			txr_q         <= '0;
			pd_q          <= '0;
			pb_q          <= '0;
			pr_q          <= '0;
			pv_q          <= 1'b0;
			idle_data_q   <= '0;
			idle_bits_q   <= IDLE_BITS_RST;
			idle_reps_q   <= '0;
			out_valid     <= 1'b0;
			track_level   <= 1'b0;
			bit_in_flight <= 1'b0;
			pending_full  <= 1'b0;
			accepted      <= 1'b0;
		end else begin
			phase_q <= phase_d;
			level_q <= level_d;
			sbit_q  <= sbit_d;
			pos_q   <= pos_d;
			txd_q   <= txd_d;
			txb_q   <= txb_d;
			txr_q   <= txr_d;
			pd_q    <= pd_d;
			pb_q    <= pb_d;
			pr_q    <= pr_d;
			pv_q    <= pv_d;
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_IDLE_DATA:    idle_data_q <= cfg_data;
					CFG_IDLE_BITS:    idle_bits_q <= cfg_data[CNT_W-1:0];
					CFG_IDLE_REPEATS: idle_reps_q <= cfg_data[REP_W-1:0];
					default:          idle_reps_q <= idle_reps_q;
				endcase
			end
			if (take) begin
				out_valid     <= 1'b1;
				track_level   <= level_d;
				bit_in_flight <= sbit_d;
				pending_full  <= pv_d;
				accepted      <= acc_d;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
